/* rtl/core/tdf_pkg.sv */
// Shared types and constants for the trial division factorizer.
package tdf_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_ITEMS      = 15;
  localparam logic [62:0] LIMIT_CEILING = 63'h7FFF_FFFF_FFFF_FFE7;
  localparam logic [62:0] LIMIT_RESET   = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic        is_zero;
    logic        neg;
    logic [63:0] mag;
    logic [62:0] limit;
  } tdf_entry_t;

endpackage

/* rtl/core/tdf_front.sv */
// Front end: limit register, input classification and a two-entry queue.
module tdf_front import tdf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [62:0] cfg_wdata,
  input  logic        start,
  input  logic [63:0] in_value,
  output logic        busy,
  output logic        q_valid,
  output tdf_entry_t  q_entry,
  input  logic        q_pop
);

  logic [62:0]           limit_r;
  tdf_entry_t            mem_r [2];
  logic                  wr_ptr_r;
  logic                  rd_ptr_r;
  logic [1:0]            cnt_r;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic [62:0]           lim;
  tdf_entry_t            ent;
  logic                  push;
  logic                  pop;

  always_comb begin
    raw = in_value[VALUE_BITS-1:0];
    mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
    if (limit_r == '0) begin
      lim = 63'd1;
    end else if (limit_r > LIMIT_CEILING) begin
      lim = LIMIT_CEILING;
    end else begin
      lim = limit_r;
    end
    ent.is_zero = (raw == '0);
    ent.neg     = raw[VALUE_BITS-1];
    ent.mag     = 64'(mag);
    ent.limit   = lim;
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_pop && q_valid;
  assign q_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RESET;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= ent;
    end
  end

endmodule

/* rtl/core/tdf_div.sv */
// Restoring divider, one quotient bit per cycle.
module tdf_div #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r;
  logic [W:0]    r_r;
  logic [W-1:0]  d_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;
  logic          done_r;
  logic [W:0]    trial;
  logic [W:0]    diff;

  always_comb begin
    trial = {r_r[W-1:0], q_r[W-1]};
    diff  = trial - {1'b0, d_r};
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
        cnt_r <= CW'(W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (run_r) begin
      if (!diff[W]) begin
        r_r <= diff;
        q_r <= {q_r[W-2:0], 1'b1};
      end else begin
        r_r <= trial;
        q_r <= {q_r[W-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/core/tdf_sqrt.sv */
// Integer square root, one result bit per cycle.
module tdf_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] x_r;
  logic [63:0] r_r;
  logic [63:0] bit_r;
  logic        run_r;
  logic        done_r;
  logic [63:0] sum;

  assign sum  = r_r + bit_r;
  assign done = done_r;
  assign root = r_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && bit_r[0]) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      x_r   <= x;
      r_r   <= '0;
      bit_r <= 64'd1 << 62;
    end else if (run_r) begin
      if (x_r >= sum) begin
        x_r <= x_r - sum;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

endmodule

/* rtl/core/tdf_back.sv */
// Back end: trial division sequencer and result output register.
module tdf_back import tdf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  tdf_entry_t  q_entry,
  output logic        q_pop,
  output logic        out_strobe,
  output logic [62:0] out_factor,
  output logic [5:0]  out_multiplicity,
  output logic [63:0] out_cofactor,
  output logic        out_status,
  output logic        out_is_last
);

  localparam int W = VALUE_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_SQRT, S_TRY, S_DIV, S_FIN1, S_FIN2
  } state_t;

  state_t      state_r;
  logic [W-1:0] rem_r;
  logic [W-1:0] d_r;
  logic [62:0] stop_r;
  logic [62:0] limit_r;
  logic [5:0]  exp_r;
  logic        neg_r;
  logic        adv_r;
  logic [3:0]  count_r;
  logic        pend_r;
  logic [62:0] pend_fac_r;
  logic [5:0]  pend_mul_r;
  logic        out_strobe_r;
  logic [62:0] out_factor_r;
  logic [5:0]  out_mul_r;
  logic [63:0] out_cof_r;
  logic        out_status_r;
  logic        out_last_r;
  logic        div_go;
  logic        sq_go;
  logic        div_done;
  logic [W-1:0] div_q;
  logic [W-1:0] div_rem;
  logic        sq_done;
  logic [31:0] sq_root;
  logic [W-1:0] d_next;
  logic [63:0] rem64;

  assign rem64  = 64'(rem_r);
  assign d_next = (d_r == W'(2)) ? W'(3) : d_r + W'(2);
  assign q_pop  = (state_r == S_IDLE) && q_valid;
  assign div_go = ((state_r == S_TRY) && (64'(d_r) <= 64'(stop_r))) ||
                  ((state_r == S_DIV) && div_done && (div_rem == '0));
  assign sq_go  = ((state_r == S_IDLE) && q_valid && !q_entry.is_zero) ||
                  ((state_r == S_DIV) && div_done && (div_rem != '0) && (exp_r != '0));

  tdf_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend ((state_r == S_DIV) ? div_q : rem_r),
    .divisor  (d_r),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  tdf_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (sq_go),
    .x     ((state_r == S_IDLE) ? q_entry.mag : rem64),
    .done  (sq_done),
    .root  (sq_root)
  );

  assign out_strobe       = out_strobe_r;
  assign out_factor       = out_factor_r;
  assign out_multiplicity = out_mul_r;
  assign out_cofactor     = out_cof_r;
  assign out_status       = out_status_r;
  assign out_is_last      = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      pend_r       <= 1'b0;
      count_r      <= '0;
      adv_r        <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            if (q_entry.is_zero) begin
              out_strobe_r <= 1'b1;
              out_factor_r <= '0;
              out_mul_r    <= '0;
              out_cof_r    <= '0;
              out_status_r <= 1'b1;
              out_last_r   <= 1'b1;
            end else begin
              rem_r   <= q_entry.mag[W-1:0];
              neg_r   <= q_entry.neg;
              limit_r <= q_entry.limit;
              stop_r  <= q_entry.limit;
              d_r     <= W'(2);
              count_r <= '0;
              pend_r  <= 1'b0;
              adv_r   <= 1'b0;
              state_r <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            if (63'(sq_root) < stop_r) begin
              stop_r <= 63'(sq_root);
            end
            if (adv_r) begin
              d_r <= d_next;
            end
            state_r <= S_TRY;
          end
        end
        S_TRY: begin
          exp_r <= '0;
          if (64'(d_r) > 64'(stop_r)) begin
            state_r <= S_FIN1;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_rem == '0) begin
              rem_r <= div_q;
              exp_r <= exp_r + 1'b1;
            end else if (exp_r != '0) begin
              if (count_r < 4'(MAX_ITEMS)) begin
                if (pend_r) begin
                  out_strobe_r <= 1'b1;
                  out_factor_r <= pend_fac_r;
                  out_mul_r    <= pend_mul_r;
                  out_cof_r    <= '0;
                  out_status_r <= 1'b0;
                  out_last_r   <= 1'b0;
                end
                pend_r     <= 1'b1;
                pend_fac_r <= 63'(d_r);
                pend_mul_r <= exp_r;
                count_r    <= count_r + 1'b1;
              end
              adv_r   <= 1'b1;
              state_r <= S_SQRT;
            end else begin
              d_r     <= d_next;
              state_r <= S_TRY;
            end
          end
        end
        S_FIN1: begin
          if ((rem64 > 64'd1) && (rem64 <= 64'(limit_r))) begin
            if (count_r < 4'(MAX_ITEMS)) begin
              if (pend_r) begin
                out_strobe_r <= 1'b1;
                out_factor_r <= pend_fac_r;
                out_mul_r    <= pend_mul_r;
                out_cof_r    <= '0;
                out_status_r <= 1'b0;
                out_last_r   <= 1'b0;
              end
              pend_r     <= 1'b1;
              pend_fac_r <= rem64[62:0];
              pend_mul_r <= 6'd1;
              count_r    <= count_r + 1'b1;
            end
            rem_r <= W'(1);
          end
          state_r <= S_FIN2;
        end
        S_FIN2: begin
          out_strobe_r <= 1'b1;
          out_factor_r <= pend_r ? pend_fac_r : '0;
          out_mul_r    <= pend_r ? pend_mul_r : '0;
          out_cof_r    <= neg_r ? (64'd0 - rem64) : rem64;
          out_status_r <= 1'b0;
          out_last_r   <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/trial_division_factorizer_top.sv */
// Trial division factorizer: top level joining front end and back end.
// Each trial divisor runs through the serial divider, and a square root follows each factor found;
// up to about 1.5 * 10^9 divisors are tried.
// Throughput: one value at a time in the back end; two more wait in the queue, busy when full.
// Results leave on a one-cycle strobe; the receiver cannot stall them.
// Reset (synchronous, rst_n low) empties the queue and sets trial_limit to 2^63-1.
module trial_division_factorizer_top import tdf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [62:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_value,
  output logic        out_strobe,
  output logic [62:0] out_factor,
  output logic [5:0]  out_multiplicity,
  output logic [63:0] out_cofactor,
  output logic        out_status,
  output logic        out_is_last
);

  logic       q_valid;
  logic       q_pop;
  tdf_entry_t q_entry;

  tdf_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .in_value  (in_value),
    .busy      (busy),
    .q_valid   (q_valid),
    .q_entry   (q_entry),
    .q_pop     (q_pop)
  );

  tdf_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .q_pop            (q_pop),
    .out_strobe       (out_strobe),
    .out_factor       (out_factor),
    .out_multiplicity (out_multiplicity),
    .out_cofactor     (out_cofactor),
    .out_status       (out_status),
    .out_is_last      (out_is_last)
  );

endmodule

/* tb/sv/trial_division_factorizer_top_tb.sv */
// Self-checking testbench for the trial division factorizer top level.
`timescale 1ns / 100ps

module trial_division_factorizer_top_tb;
  import tdf_pkg::*;

  localparam int             IDLE_LIMIT   = 200000;
  localparam int             DRAIN_CYCLES = 200;
  localparam logic [63:0]    MOST_NEG     = 64'h8000_0000_0000_0000;
  localparam logic [63:0]    MOST_POS     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam longint unsigned PRIMORIAL_47 = 64'd614889782588491410;
  localparam logic           ST_OK        = 1'b0;
  localparam logic           ST_ZERO      = 1'b1;

  typedef struct packed {
    logic [62:0] factor;
    logic [5:0]  multiplicity;
    logic [63:0] cofactor;
    logic        status;
    logic        is_last;
  } factor_item_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [62:0] cfg_wdata;
  logic        start;
  logic        busy;
  logic [63:0] in_value;
  logic        out_strobe;
  logic [62:0] out_factor;
  logic [5:0]  out_multiplicity;
  logic [63:0] out_cofactor;
  logic        out_status;
  logic        out_is_last;

  factor_item_t expected_factors[$];
  logic [62:0]  trial_limit_model;
  int           fail_count;
  int           idle_cycles;
  bit           gaps_on;
  int           small_primes[25] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47,
                                     53, 59, 61, 67, 71, 73, 79, 83, 89, 97};

  trial_division_factorizer_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .out_strobe       (out_strobe),
    .out_factor       (out_factor),
    .out_multiplicity (out_multiplicity),
    .out_cofactor     (out_cofactor),
    .out_status       (out_status),
    .out_is_last      (out_is_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint unsigned isqrt64(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void queue_expected(input factor_item_t item);
    expected_factors.insert(expected_factors.size(), item);
  endfunction

  task automatic predict_factors(input logic [63:0] value);
    factor_item_t    items[MAX_ITEMS];
    factor_item_t    item;
    int              count;
    logic            neg;
    longint unsigned rem;
    longint unsigned lim;
    longint unsigned bound;
    longint unsigned div;
    longint unsigned mult;
    count = 0;
    item  = '0;
    if (value == 64'd0) begin
      item.status  = ST_ZERO;
      item.is_last = 1'b1;
      queue_expected(item);
      return;
    end
    neg = value[63];
    rem = neg ? (~value + 64'd1) : value;
    lim = {1'b0, trial_limit_model};
    if (lim < 1) lim = 1;
    if (lim > {1'b0, LIMIT_CEILING}) lim = {1'b0, LIMIT_CEILING};
    bound = lim;
    if (rem / bound < bound) bound = isqrt64(rem);
    div = 2;
    while (div <= bound) begin
      if (rem % div == 0) begin
        mult = 0;
        while (rem % div == 0) begin
          rem  = rem / div;
          mult = mult + 1;
        end
        if (count < MAX_ITEMS) begin
          item = '0;
          item.factor       = div[62:0];
          item.multiplicity = mult[5:0];
          items[count] = item;
          count++;
        end
        if (rem / bound < bound) bound = isqrt64(rem);
      end
      div = (div == 2) ? 3 : div + 2;
    end
    if (rem > 1 && rem <= lim) begin
      if (count < MAX_ITEMS) begin
        item = '0;
        item.factor       = rem[62:0];
        item.multiplicity = 6'd1;
        items[count] = item;
        count++;
      end
      rem = 1;
    end
    if (count == 0) begin
      items[0] = '0;
      count = 1;
    end
    items[count-1].cofactor = neg ? (64'd0 - rem) : rem;
    items[count-1].is_last  = 1'b1;
    for (int i = 0; i < count; i++) queue_expected(items[i]);
  endtask

  task automatic random_gap();
    int n;
    n = 0;
    if (gaps_on && $urandom_range(0, 2) == 0) n = $urandom_range(1, 3);
    repeat (n) begin
      @(negedge clk);
      start    = 1'b0;
      in_value = {$urandom, $urandom};
    end
  endtask

  task automatic send_value(input logic [63:0] value);
    random_gap();
    @(negedge clk);
    start    = 1'b1;
    in_value = value;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_factors(value);
  endtask

  task automatic end_burst();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_idle();
    end_burst();
    wait (expected_factors.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [62:0] limit);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = limit;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = 63'({$urandom, $urandom});
    trial_limit_model = limit;
  endtask

  function automatic logic [63:0] smooth_value();
    longint unsigned mag;
    int              p;
    mag = 1;
    repeat ($urandom_range(1, 10)) begin
      p = small_primes[5'($urandom_range(0, 24))];
      if (mag <= (64'd1 << 62) / p) mag = mag * p;
    end
    if ($urandom_range(0, 3) == 0) mag = 64'($urandom_range(1, 65535));
    return $urandom_range(0, 1) ? (64'd0 - mag) : mag;
  endfunction

  task automatic test_special_values();
    send_value(64'd0);
    send_value(64'd1);
    send_value(-64'd1);
    send_value(64'd2);
    send_value(-64'd2);
    send_value(MOST_NEG);
    send_value(64'd1 << 62);
    send_value(-64'd360);
    send_value(64'd65521);
    send_value(-64'd65521);
    send_value(PRIMORIAL_47);
    send_value(-(PRIMORIAL_47 * 3));
    send_value(64'd97 * 64'd97 * 64'd89);
  endtask

  task automatic test_limit_extremes();
    write_limit(63'd1);
    send_value(MOST_POS);
    send_value(MOST_NEG);
    send_value(-64'd12);
    write_limit(63'd0);
    send_value(64'd12);
    send_value(MOST_NEG + 64'd1);
    write_limit(63'd3);
    send_value(MOST_POS);
    send_value(64'd36);
    send_value(-64'd35);
    send_value(64'd0);
  endtask

  task automatic test_random_full_width();
    for (int k = 0; k < 4; k++) begin
      write_limit(63'($urandom_range(1, 300)));
      repeat (9) send_value({$urandom, $urandom});
    end
  endtask

  task automatic test_moderate_limit();
    for (int k = 0; k < 3; k++) begin
      write_limit(63'($urandom_range(5, 60)));
      repeat (7) send_value(smooth_value());
    end
  endtask

  task automatic test_full_limit_smooth();
    write_limit(63'h7FFF_FFFF_FFFF_FFFF);
    repeat (20) send_value(smooth_value());
    gaps_on = 1'b0;
    repeat (15) send_value(smooth_value());
    end_burst();
  endtask

  always @(posedge clk) begin
    factor_item_t exp_item;
    if (rst_n && out_strobe) begin
      if (expected_factors.size() == 0) begin
        $error("unexpected result: factor %0d cofactor %0d", out_factor, $signed(out_cofactor));
        fail_count++;
      end else begin
        exp_item = expected_factors.pop_front();
        if (out_factor !== exp_item.factor) begin
          $error("factor: expected %0d, actual %0d", exp_item.factor, out_factor);
          fail_count++;
        end
        if (out_multiplicity !== exp_item.multiplicity) begin
          $error("multiplicity: expected %0d, actual %0d", exp_item.multiplicity,
                 out_multiplicity);
          fail_count++;
        end
        if (out_cofactor !== exp_item.cofactor) begin
          $error("cofactor: expected %0d, actual %0d", $signed(exp_item.cofactor),
                 $signed(out_cofactor));
          fail_count++;
        end
        if (out_status !== exp_item.status) begin
          $error("status: expected %0d, actual %0d", exp_item.status, out_status);
          fail_count++;
        end
        if (out_is_last !== exp_item.is_last) begin
          $error("is_last: expected %0d, actual %0d", exp_item.is_last, out_is_last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_strobe || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("trial_division_factorizer_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    fail_count        = 0;
    idle_cycles       = 0;
    gaps_on           = 1'b1;
    trial_limit_model = LIMIT_RESET;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    start             = 1'b0;
    in_value          = '0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_special_values();
    test_limit_extremes();
    test_random_full_width();
    test_moderate_limit();
    test_full_limit_smooth();
    wait (expected_factors.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("trial_division_factorizer_top verification clean");
    end else begin
      $display("trial_division_factorizer_top verification failed");
    end
    $finish;
  end

endmodule
